// ----- src/prp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package prp_pkg;

  localparam int NUM_PROCS_DEF  = 4;
  localparam int MAX_FRAMES_DEF = 16;
  localparam int MAX_PAGES_DEF  = 64;

  localparam int ADDR_W  = 15;
  localparam int PS_W    = 10;
  localparam int CFG_W   = 10;
  localparam int CFG_IW  = 3;
  localparam int OUTPG_W = 6;
  localparam int SWAP_W  = 16;

  typedef enum logic [CFG_IW-1:0] {
    CFG_POLICY  = 3'd0,
    CFG_PREPAGE = 3'd1,
    CFG_FRAMES  = 3'd2,
    CFG_PSIZE   = 3'd3,
    CFG_PAGES0  = 3'd4,
    CFG_PAGES1  = 3'd5,
    CFG_PAGES2  = 3'd6,
    CFG_PAGES3  = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;

  localparam logic [1:0] PH_HIT = 2'd0;
  localparam logic [1:0] PH_L1  = 2'd1;
  localparam logic [1:0] PH_L2  = 2'd2;

endpackage
`default_nettype wire

// ----- src/prp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module prp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/page_replacement_policy.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i/in_ready_o   cmd_i, process_id_i, address_i
// out      out  out_valid_o/out_ready_i hit_o .. swap_count_o
// cfg      in   cfg_we_i (no wait)      cfg_index_i, cfg_data_i
//
// One beat at a time. After the accept cycle a restoring divider forms the page number
// and the residency table is read; a hit then ends, or under LRU scans the frames and
// shifts the found page to the back. A fault runs the prepage search when enabled,
// probing pages above the faulting one, then each load; when full, a load takes one
// capture and shifts the frames (FIFO/LRU) or steps the hand (Clock, up to 2F+3 steps).
// Init and the pass after reset sweep the residency table, one entry a cycle, with
// the input held not ready. A finished result waits in the output register while
// the next beat is taken, and holds the sequencer if busy.
module page_replacement_policy #(
  parameter int NUM_PROCS  = prp_pkg::NUM_PROCS_DEF,
  parameter int MAX_FRAMES = prp_pkg::MAX_FRAMES_DEF,
  parameter int MAX_PAGES  = prp_pkg::MAX_PAGES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [prp_pkg::CFG_IW-1:0]    cfg_index_i,
  input  wire logic [prp_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [1:0]                    process_id_i,
  input  wire logic [prp_pkg::ADDR_W-1:0]    address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               hit_o,
  output logic                               fault_o,
  output logic [1:0]                         evictions_o,
  output logic [prp_pkg::OUTPG_W-1:0]        victim_page_o,
  output logic                               prepaged_o,
  output logic [prp_pkg::OUTPG_W-1:0]        prepaged_page_o,
  output logic                               out_of_range_o,
  output logic [prp_pkg::SWAP_W-1:0]         swap_count_o
);
  import prp_pkg::*;

  localparam int PGW = $clog2(MAX_PAGES);
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int NW  = $clog2(2 * MAX_FRAMES + 3);
  localparam int PIW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int PNW = $clog2(NUM_PROCS + 1);
  localparam int RD  = NUM_PROCS * MAX_FRAMES;
  localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
  localparam int BD  = NUM_PROCS * MAX_PAGES;
  localparam int BW  = $clog2(BD);

  // residency table entry: resident bit above reference bit
  localparam int RES_B = 1;
  localparam int REF_B = 0;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DIV     = 5'd1;
  localparam logic [4:0] S_CHECK   = 5'd2;
  localparam logic [4:0] S_RES     = 5'd3;
  localparam logic [4:0] S_LRU_RD  = 5'd4;
  localparam logic [4:0] S_LRU_CMP = 5'd5;
  localparam logic [4:0] S_SRCH    = 5'd6;
  localparam logic [4:0] S_SRCH_CK = 5'd7;
  localparam logic [4:0] S_LOAD    = 5'd8;
  localparam logic [4:0] S_EV_CAP  = 5'd9;
  localparam logic [4:0] S_SH_RD   = 5'd10;
  localparam logic [4:0] S_SH_WR   = 5'd11;
  localparam logic [4:0] S_CK_RD   = 5'd12;
  localparam logic [4:0] S_CK_REF  = 5'd13;
  localparam logic [4:0] S_CK_EV   = 5'd14;
  localparam logic [4:0] S_POST    = 5'd15;
  localparam logic [4:0] S_INIT    = 5'd16;
  localparam logic [4:0] S_OUT     = 5'd17;

  // configuration
  logic [1:0]      policy_q;
  logic            prepage_q;
  logic [4:0]      frames_q;
  logic [PS_W-1:0] psize_q;
  logic [6:0]      pages_q [4];

  // per-process state
  logic [FCW-1:0]  fill_q [NUM_PROCS];
  logic [FIW-1:0]  hand_q [NUM_PROCS];
  logic [SWAP_W-1:0] swap_q;

  // sequencer
  logic [4:0]        state_q;
  logic [1:0]        pid_q;
  logic [ADDR_W-1:0] quo_q;
  logic [PS_W-1:0]   rem_q;
  logic [3:0]        dcnt_q;
  logic [PGW-1:0]    page_q;
  logic [PGW-1:0]    fpage_q;
  logic              prot_q;
  logic [1:0]        phase_q;
  logic              found_q;
  logic [PCW-1:0]    q_q;
  logic [FCW-1:0]    k_q;
  logic [FIW-1:0]    h_q;
  logic [NW-1:0]     n_q;
  logic              final_q;
  logic [PNW-1:0]    p_q;
  logic [PGW-1:0]    pg_q;
  logic              clr_q;
  logic [PGW-1:0]    ck_pg_q;

  // result being built
  logic           hit_q, fault_q, prepaged_q, oor_q;
  logic [1:0]     evc_q;
  logic [PGW-1:0] victim_q, pre_q;

  // frame-table RAM port
  logic           ram_we;
  logic [RAW-1:0] ram_waddr, ram_raddr;
  logic [PGW-1:0] ram_wdata, ram_rdata;

  // residency-table RAM port
  logic          bit_we;
  logic [BW-1:0] bit_waddr, bit_raddr;
  logic [1:0]    bit_wdata, bit_rdata;

  function automatic logic [RAW-1:0] f_addr(input logic [31:0] p, input logic [31:0] i);
    return RAW'(p * MAX_FRAMES + i);
  endfunction

  function automatic logic [BW-1:0] f_bit(input logic [31:0] p, input logic [31:0] pg);
    return BW'(p * MAX_PAGES + pg);
  endfunction

  function automatic logic [PCW-1:0] f_pages(input logic [6:0] raw);
    logic [31:0] v;
    v = 32'(raw);
    if (v == 0) v = 1;
    if (v > MAX_PAGES) v = MAX_PAGES;
    return PCW'(v);
  endfunction

  // derived views
  logic [PIW-1:0]    pix;
  logic [FCW-1:0]    fill_cur;
  logic [FCW-1:0]    frames_eff;
  logic [PCW-1:0]    pages_cur;
  logic [PS_W-1:0]   psize_eff;
  logic [PS_W:0]     rem_sh;
  logic              div_ge;
  logic              ck_prot;
  logic              ck_take;
  logic [FIW-1:0]    ck_next;
  logic [PIW-1:0]    pix_init;
  logic [PCW-1:0]    init_pages;
  logic [FCW-1:0]    init_n;
  logic              init_load;
  logic              init_pg_last;

  always_comb begin
    logic [31:0] fv;
    fv = 32'(frames_q);
    if (fv == 0) fv = 1;
    if (fv > MAX_FRAMES) fv = MAX_FRAMES;
    frames_eff = FCW'(fv);
  end

  assign pix       = PIW'(pid_q);
  assign fill_cur  = fill_q[pix];
  assign pages_cur = f_pages(pages_q[pid_q]);
  assign psize_eff = (psize_q == '0) ? PS_W'(1) : psize_q;
  assign rem_sh    = {rem_q, quo_q[ADDR_W-1]};
  assign div_ge    = rem_sh >= {1'b0, psize_eff};

  // take the frame at the hand unless referenced or the faulted page, or on the final step
  assign ck_prot = prot_q && (ck_pg_q == fpage_q);
  assign ck_take = final_q || (!ck_prot && !bit_rdata[REF_B]);
  assign ck_next = ((FCW'(h_q) + FCW'(1)) < fill_cur) ? (h_q + FIW'(1)) : '0;

  assign pix_init     = PIW'(p_q);
  assign init_pages   = (32'(p_q) < 4) ? f_pages(pages_q[2'(p_q)]) : PCW'(1);
  assign init_n       = (32'(frames_eff) > 32'(init_pages)) ? FCW'(init_pages) : frames_eff;
  assign init_load    = !clr_q && (32'(pg_q) < 32'(init_n));
  assign init_pg_last = (pg_q == PGW'(MAX_PAGES - 1));

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    bit_we    = 1'b0;
    bit_waddr = '0;
    bit_wdata = '0;
    bit_raddr = '0;
    unique case (state_q)
      S_CHECK: bit_raddr = f_bit(32'(pid_q), 32'(quo_q));
      S_RES: begin
        // Clock hit: mark the page referenced
        if (bit_rdata[RES_B] && (policy_q == POL_CLOCK)) begin
          bit_we    = 1'b1;
          bit_waddr = f_bit(32'(pid_q), 32'(page_q));
          bit_wdata = 2'b11;
        end
      end
      S_SRCH: bit_raddr = f_bit(32'(pid_q), 32'(q_q));
      S_LRU_RD: ram_raddr = f_addr(32'(pid_q), 32'(k_q));
      S_SH_RD: begin
        if (k_q == fill_cur) begin
          ram_we    = 1'b1;
          ram_waddr = f_addr(32'(pid_q), 32'(k_q) - 1);
          ram_wdata = page_q;
        end else begin
          ram_raddr = f_addr(32'(pid_q), 32'(k_q));
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = f_addr(32'(pid_q), 32'(k_q) - 1);
        ram_wdata = ram_rdata;
      end
      S_LOAD: begin
        if (fill_cur < frames_eff) begin
          ram_we    = 1'b1;
          ram_waddr = f_addr(32'(pid_q), 32'(fill_cur));
          ram_wdata = page_q;
        end else if (policy_q != POL_CLOCK) begin
          ram_raddr = f_addr(32'(pid_q), 32'd0);
        end
      end
      S_EV_CAP: begin
        // drop the queue-front page
        bit_we    = 1'b1;
        bit_waddr = f_bit(32'(pid_q), 32'(ram_rdata));
        bit_wdata = 2'b00;
      end
      S_CK_RD: ram_raddr = f_addr(32'(pid_q), 32'(h_q));
      S_CK_REF: bit_raddr = f_bit(32'(pid_q), 32'(ram_rdata));
      S_CK_EV: begin
        if (ck_take) begin
          ram_we    = 1'b1;
          ram_waddr = f_addr(32'(pid_q), 32'(h_q));
          ram_wdata = page_q;
          bit_we    = 1'b1;
          bit_waddr = f_bit(32'(pid_q), 32'(ck_pg_q));
          bit_wdata = 2'b00;
        end else if (!ck_prot) begin
          // second chance: clear the reference bit, keep residency
          bit_we    = 1'b1;
          bit_waddr = f_bit(32'(pid_q), 32'(ck_pg_q));
          bit_wdata = {bit_rdata[RES_B], 1'b0};
        end
      end
      S_POST: begin
        // the loaded page becomes resident and unreferenced
        if (phase_q != PH_HIT) begin
          bit_we    = 1'b1;
          bit_waddr = f_bit(32'(pid_q), 32'(page_q));
          bit_wdata = 2'b10;
        end
      end
      S_INIT: begin
        bit_we    = 1'b1;
        bit_waddr = f_bit(32'(p_q), 32'(pg_q));
        bit_wdata = {init_load, 1'b0};
        if (init_load) begin
          ram_we    = 1'b1;
          ram_waddr = f_addr(32'(p_q), 32'(pg_q));
          ram_wdata = pg_q;
        end
      end
      default: ;
    endcase
  end

  prp_ram #(
    .WIDTH (PGW),
    .DEPTH (RD),
    .AW    (RAW)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  prp_ram #(
    .WIDTH (2),
    .DEPTH (BD),
    .AW    (BW)
  ) u_bits (
    .clk_i   (clk_i),
    .we_i    (bit_we),
    .waddr_i (bit_waddr),
    .wdata_i (bit_wdata),
    .raddr_i (bit_raddr),
    .rdata_o (bit_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= POL_FIFO;
      prepage_q  <= 1'b0;
      frames_q   <= 5'd4;
      psize_q    <= PS_W'(32);
      pages_q[0] <= 7'd64;
      pages_q[1] <= 7'd64;
      pages_q[2] <= 7'd64;
      pages_q[3] <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POLICY:  policy_q   <= cfg_data_i[1:0];
        CFG_PREPAGE: prepage_q  <= cfg_data_i[0];
        CFG_FRAMES:  frames_q   <= cfg_data_i[4:0];
        CFG_PSIZE:   psize_q    <= cfg_data_i;
        CFG_PAGES0:  pages_q[0] <= cfg_data_i[6:0];
        CFG_PAGES1:  pages_q[1] <= cfg_data_i[6:0];
        CFG_PAGES2:  pages_q[2] <= cfg_data_i[6:0];
        CFG_PAGES3:  pages_q[3] <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer and per-process state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // clear the residency table before the first beat
      state_q     <= S_INIT;
      clr_q       <= 1'b1;
      p_q         <= '0;
      pg_q        <= '0;
      swap_q      <= '0;
      fill_q      <= '{default: '0};
      hand_q      <= '{default: '0};
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && (state_q != S_OUT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pid_q      <= process_id_i;
            hit_q      <= 1'b0;
            fault_q    <= 1'b0;
            prepaged_q <= 1'b0;
            oor_q      <= 1'b0;
            evc_q      <= 2'd0;
            victim_q   <= '0;
            pre_q      <= '0;
            if (cmd_i) begin
              // init: rewrite residency and frames in one sweep
              hand_q  <= '{default: '0};
              swap_q  <= '0;
              clr_q   <= 1'b0;
              p_q     <= '0;
              pg_q    <= '0;
              state_q <= S_INIT;
            end else begin
              quo_q   <= address_i;
              rem_q   <= '0;
              dcnt_q  <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q  <= div_ge ? PS_W'(rem_sh - {1'b0, psize_eff}) : rem_sh[PS_W-1:0];
          quo_q  <= {quo_q[ADDR_W-2:0], div_ge};
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'(ADDR_W - 1)) state_q <= S_CHECK;
        end
        S_CHECK: begin
          if ((32'(pid_q) >= NUM_PROCS) || (quo_q >= ADDR_W'(pages_cur))) begin
            oor_q   <= 1'b1;
            state_q <= S_OUT;
          end else begin
            page_q  <= quo_q[PGW-1:0];
            fpage_q <= quo_q[PGW-1:0];
            prot_q  <= 1'b0;
            state_q <= S_RES;
          end
        end
        S_RES: begin
          if (bit_rdata[RES_B]) begin
            hit_q   <= 1'b1;
            phase_q <= PH_HIT;
            k_q     <= '0;
            state_q <= (policy_q == POL_LRU) ? S_LRU_RD : S_OUT;
          end else begin
            fault_q <= 1'b1;
            phase_q <= PH_L1;
            found_q <= 1'b0;
            q_q     <= PCW'(page_q) + PCW'(1);
            if (prepage_q && (32'(frames_eff) >= 2)) state_q <= S_SRCH;
            else state_q <= S_LOAD;
          end
        end
        S_LRU_RD: begin
          state_q <= (k_q == fill_cur) ? S_OUT : S_LRU_CMP;
        end
        S_LRU_CMP: begin
          k_q <= k_q + FCW'(1);
          // found: close the gap and move the page to the back
          state_q <= (ram_rdata == page_q) ? S_SH_RD : S_LRU_RD;
        end
        S_SRCH: begin
          state_q <= (q_q >= pages_cur) ? S_LOAD : S_SRCH_CK;
        end
        S_SRCH_CK: begin
          if (!bit_rdata[RES_B]) begin
            found_q <= 1'b1;
            pre_q   <= PGW'(q_q);
            state_q <= S_LOAD;
          end else begin
            q_q     <= q_q + PCW'(1);
            state_q <= S_SRCH;
          end
        end
        S_LOAD: begin
          if (fill_cur < frames_eff) begin
            fill_q[pix] <= fill_cur + FCW'(1);
            state_q <= S_POST;
          end else if (policy_q == POL_CLOCK) begin
            h_q     <= (FCW'(hand_q[pix]) >= fill_cur) ? '0 : hand_q[pix];
            n_q     <= '0;
            final_q <= 1'b0;
            state_q <= S_CK_RD;
          end else begin
            state_q <= S_EV_CAP;
          end
        end
        S_EV_CAP: begin
          // queue front is the victim
          if (evc_q == 2'd0) victim_q <= ram_rdata;
          evc_q   <= evc_q + 2'd1;
          k_q     <= FCW'(1);
          state_q <= S_SH_RD;
        end
        S_SH_RD: begin
          state_q <= (k_q == fill_cur) ? S_POST : S_SH_WR;
        end
        S_SH_WR: begin
          k_q     <= k_q + FCW'(1);
          state_q <= S_SH_RD;
        end
        S_CK_RD: begin
          state_q <= S_CK_REF;
        end
        S_CK_REF: begin
          ck_pg_q <= ram_rdata;
          state_q <= S_CK_EV;
        end
        S_CK_EV: begin
          if (ck_take) begin
            hand_q[pix] <= ck_next;
            if (evc_q == 2'd0) victim_q <= ck_pg_q;
            evc_q   <= evc_q + 2'd1;
            state_q <= S_POST;
          end else begin
            h_q <= ck_next;
            n_q <= n_q + NW'(1);
            if ((32'(n_q) + 1) == (2 * 32'(fill_cur) + 2)) final_q <= 1'b1;
            state_q <= S_CK_RD;
          end
        end
        S_POST: begin
          if ((phase_q == PH_L1) && found_q) begin
            phase_q    <= PH_L2;
            page_q     <= pre_q;
            prot_q     <= 1'b1;
            prepaged_q <= 1'b1;
            state_q    <= S_LOAD;
          end else begin
            if ((evc_q != 2'd0) && (swap_q != '1)) swap_q <= swap_q + SWAP_W'(1);
            state_q <= S_OUT;
          end
        end
        S_INIT: begin
          if (init_pg_last) begin
            pg_q <= '0;
            if (!clr_q) fill_q[pix_init] <= init_n;
            if (32'(p_q) == NUM_PROCS - 1) begin
              state_q <= clr_q ? S_IDLE : S_OUT;
            end else begin
              p_q <= p_q + PNW'(1);
            end
          end else begin
            pg_q <= pg_q + PGW'(1);
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_o || out_ready_i) begin
            out_valid_o     <= 1'b1;
            hit_o           <= hit_q;
            fault_o         <= fault_q;
            evictions_o     <= evc_q;
            victim_page_o   <= OUTPG_W'(victim_q);
            prepaged_o      <= prepaged_q;
            prepaged_page_o <= OUTPG_W'(pre_q);
            out_of_range_o  <= oor_q;
            swap_count_o    <= swap_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/prp_checker.sv -----
`timescale 1ns / 1ps
module prp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [prp_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [prp_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         cmd_i,
  input  logic [1:0]                   process_id_i,
  input  logic [prp_pkg::ADDR_W-1:0]   address_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         hit_i,
  input  logic                         fault_i,
  input  logic [1:0]                   evictions_i,
  input  logic [prp_pkg::OUTPG_W-1:0]  victim_page_i,
  input  logic                         prepaged_i,
  input  logic [prp_pkg::OUTPG_W-1:0]  prepaged_page_i,
  input  logic                         out_of_range_i,
  input  logic [prp_pkg::SWAP_W-1:0]   swap_count_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import prp_pkg::*;

  localparam int NPROC = NUM_PROCS_DEF;
  localparam int NFRM  = MAX_FRAMES_DEF;
  localparam int NPG   = MAX_PAGES_DEF;

  typedef struct packed {
    logic               hit;
    logic               fault;
    logic [1:0]         evictions;
    logic [OUTPG_W-1:0] victim;
    logic               prepaged;
    logic [OUTPG_W-1:0] pre_page;
    logic               oor;
    logic [SWAP_W-1:0]  swaps;
  } access_res_t;

  // Register shadows
  logic [1:0] policy;
  logic       prepage_on;
  logic [4:0] frames_reg;
  logic [9:0] psize_reg;
  logic [6:0] pages_reg [NPROC];

  // Replacement state shadows
  logic [5:0]  frame_tbl [NPROC*NFRM];
  int          fill_cnt  [NPROC];
  logic        resident  [NPROC*NPG];
  logic        refd      [NPROC*NPG];
  int          hand      [NPROC];
  logic [15:0] swap_total;

  access_res_t expected_results [$];
  int fails;

  assign pending_o    = expected_results.size();
  assign fail_count_o = fails;

  function automatic int eff_frames();
    int f;
    f = frames_reg;
    if (f == 0) f = 1;
    if (f > NFRM) f = NFRM;
    return f;
  endfunction

  function automatic int eff_pages(int p);
    int n;
    n = pages_reg[p];
    if (n == 0) n = 1;
    if (n > NPG) n = NPG;
    return n;
  endfunction

  // Sweep the hand of one process; the protected page is passed over untouched.
  function automatic int clock_sweep(int p, int fill, int protect, bit has_protect);
    int h;
    int pg;
    h = hand[p];
    if (h >= fill) h = 0;
    for (int n = 0; n < 2 * fill + 2; n++) begin
      pg = frame_tbl[p*NFRM + h];
      if (!(has_protect && pg == protect)) begin
        if (!refd[p*NPG + pg]) return h;
        refd[p*NPG + pg] = 1'b0;
      end
      h = (h + 1 < fill) ? h + 1 : 0;
    end
    return h;
  endfunction

  function automatic bit load_page(int p, int page, int protect, bit has_protect,
                                   output int victim);
    int fill;
    int slot;
    int old;
    int b;
    b      = p * NFRM;
    fill   = fill_cnt[p];
    victim = 0;
    if (fill < eff_frames()) begin
      frame_tbl[b + fill] = page;
      fill_cnt[p]         = fill + 1;
      resident[p*NPG + page] = 1'b1;
      refd[p*NPG + page]     = 1'b0;
      return 1'b0;
    end
    if (policy == POL_CLOCK) begin
      slot = clock_sweep(p, fill, protect, has_protect);
      old  = frame_tbl[b + slot];
      frame_tbl[b + slot] = page;
      hand[p] = (slot + 1 < fill) ? slot + 1 : 0;
    end else begin
      old = frame_tbl[b];
      for (int j = 0; j < fill - 1; j++) frame_tbl[b + j] = frame_tbl[b + j + 1];
      frame_tbl[b + fill - 1] = page;
    end
    resident[p*NPG + old]  = 1'b0;
    refd[p*NPG + old]      = 1'b0;
    resident[p*NPG + page] = 1'b1;
    refd[p*NPG + page]     = 1'b0;
    victim = old;
    return 1'b1;
  endfunction

  function automatic access_res_t predict_access(logic c, int p, int addr);
    access_res_t r;
    int ps, page, n, b, fill, q, v1, v2, ev;
    bit found;
    r  = '0;
    ev = 0;
    v1 = 0;
    if (c) begin
      foreach (resident[i]) begin
        resident[i] = 1'b0;
        refd[i]     = 1'b0;
      end
      swap_total = '0;
      for (int k = 0; k < NPROC; k++) begin
        hand[k] = 0;
        n = eff_frames();
        if (n > eff_pages(k)) n = eff_pages(k);
        for (int j = 0; j < n; j++) begin
          frame_tbl[k*NFRM + j] = j;
          resident[k*NPG + j]   = 1'b1;
        end
        fill_cnt[k] = n;
      end
    end else begin
      ps   = (psize_reg == 0) ? 1 : psize_reg;
      page = addr / ps;
      if (page >= eff_pages(p)) begin
        r.oor = 1'b1;
      end else if (resident[p*NPG + page]) begin
        r.hit = 1'b1;
        if (policy == POL_CLOCK) begin
          refd[p*NPG + page] = 1'b1;
        end else if (policy == POL_LRU) begin
          b    = p * NFRM;
          fill = fill_cnt[p];
          for (int j = 0; j < fill; j++) begin
            if (frame_tbl[b + j] == page) begin
              for (int k = j; k < fill - 1; k++) frame_tbl[b + k] = frame_tbl[b + k + 1];
              frame_tbl[b + fill - 1] = page;
              break;
            end
          end
        end
      end else begin
        r.fault = 1'b1;
        found   = 1'b0;
        q       = 0;
        if (prepage_on && eff_frames() >= 2) begin
          for (q = page + 1; q < eff_pages(p); q++) begin
            if (!resident[p*NPG + q]) begin
              found = 1'b1;
              break;
            end
          end
        end
        if (load_page(p, page, 0, 1'b0, v1)) ev = 1;
        if (found) begin
          r.prepaged = 1'b1;
          r.pre_page = q;
          if (load_page(p, q, page, 1'b1, v2)) begin
            if (ev == 0) v1 = v2;
            ev++;
          end
        end
        if (ev > 0 && swap_total != 16'hFFFF) swap_total++;
        r.evictions = ev;
        r.victim    = (ev > 0) ? v1 : 0;
      end
    end
    r.swaps = swap_total;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_res_t want;
    if (!rst_ni) begin
      policy     = POL_FIFO;
      prepage_on = 1'b0;
      frames_reg = 5'd4;
      psize_reg  = 10'd32;
      for (int k = 0; k < NPROC; k++) begin
        pages_reg[k] = 7'd64;
        fill_cnt[k]  = 0;
        hand[k]      = 0;
      end
      foreach (resident[i]) begin
        resident[i] = 1'b0;
        refd[i]     = 1'b0;
      end
      swap_total = '0;
      expected_results.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_POLICY:  policy     = cfg_data_i[1:0];
          CFG_PREPAGE: prepage_on = cfg_data_i[0];
          CFG_FRAMES:  frames_reg = cfg_data_i[4:0];
          CFG_PSIZE:   psize_reg  = cfg_data_i[9:0];
          CFG_PAGES0:  pages_reg[0] = cfg_data_i[6:0];
          CFG_PAGES1:  pages_reg[1] = cfg_data_i[6:0];
          CFG_PAGES2:  pages_reg[2] = cfg_data_i[6:0];
          CFG_PAGES3:  pages_reg[3] = cfg_data_i[6:0];
          default: ;
        endcase
      end
      // Queue the prediction before taking the oldest, in case a beat turns round at once
      if (in_valid_i && in_ready_i)
        expected_results.insert(expected_results.size(),
                                predict_access(cmd_i, process_id_i, address_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("mismatch: result beat with nothing expected");
          fails++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (hit_i != want.hit) report("hit", hit_i, want.hit);
          if (fault_i != want.fault) report("fault", fault_i, want.fault);
          if (evictions_i != want.evictions) report("evictions", evictions_i, want.evictions);
          if (victim_page_i != want.victim) report("victim_page", victim_page_i, want.victim);
          if (prepaged_i != want.prepaged) report("prepaged", prepaged_i, want.prepaged);
          if (prepaged_page_i != want.pre_page)
            report("prepaged_page", prepaged_page_i, want.pre_page);
          if (out_of_range_i != want.oor) report("out_of_range", out_of_range_i, want.oor);
          if (swap_count_i != want.swaps) report("swap_count", swap_count_i, want.swaps);
        end
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import prp_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 240;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                cmd_i = 1'b0;
  logic [1:0]          process_id_i = '0;
  logic [ADDR_W-1:0]   address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                hit_o, fault_o, prepaged_o, out_of_range_o;
  logic [1:0]          evictions_o;
  logic [OUTPG_W-1:0]  victim_page_o, prepaged_page_o;
  logic [SWAP_W-1:0]   swap_count_o;

  int pending, fails;
  bit idling_on = 1'b1;
  int quiet_cycles = 0;

  // Stimulus-side copy of the settings, only to aim addresses at real pages
  int cur_frames = 4;
  int cur_psize  = 32;
  int cur_pages [4] = '{64, 64, 64, 64};

  // Phase table: policy, prepage, frames, page size, page counts per process.
  // Raw codes beyond range (policy three, zeros, 31, 127) sit in phase 3.
  int ph_pol [PHASES] = '{0, 1, 2, 3, 2, 1, 0, 2};
  int ph_pre [PHASES] = '{0, 1, 1, 1, 1, 0, 1, 0};
  int ph_frm [PHASES] = '{4, 16, 1, 31, 3, 8, 2, 5};
  int ph_psz [PHASES] = '{32, 512, 1, 0, 64, 16, 1023, 128};
  int ph_pgs [PHASES][4] = '{'{64, 64, 64, 64}, '{64, 64, 64, 64}, '{1, 64, 7, 33},
                             '{0, 127, 2, 64}, '{10, 20, 40, 64}, '{64, 5, 64, 12},
                             '{64, 64, 3, 32}, '{64, 64, 64, 64}};
  // Phase 6 keeps the old queues, so processes hold more frames than allotted
  bit  ph_init [PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  page_replacement_policy dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .process_id_i, .address_i,
    .out_valid_o, .out_ready_i, .hit_o, .fault_o, .evictions_o, .victim_page_o,
    .prepaged_o, .prepaged_page_o, .out_of_range_o, .swap_count_o
  );

  prp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .process_id_i, .address_i,
    .out_valid_i(out_valid_o), .out_ready_i, .hit_i(hit_o), .fault_i(fault_o),
    .evictions_i(evictions_o), .victim_page_i(victim_page_o), .prepaged_i(prepaged_o),
    .prepaged_page_i(prepaged_page_o), .out_of_range_i(out_of_range_o),
    .swap_count_i(swap_count_o), .pending_o(pending), .fail_count_o(fails)
  );

  // Watchdog: count cycles in which no beat moves on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Result side: ready in random bursts, held high once idling is switched off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
    end
  end

  // Offer one beat; valid is left high so back-to-back beats need no toggle
  task automatic send_beat(logic c, int p, int addr);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    process_id_i <= p[1:0];
    address_i    <= addr[ADDR_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold the sender until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(int pol, int pre, int frm, int psz, int pg0, int pg1,
                            int pg2, int pg3);
    int vals [8];
    vals = '{pol, pre, frm, psz, pg0, pg1, pg2, pg3};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= i[CFG_IW-1:0];
      cfg_data_i  <= vals[i][CFG_W-1:0];
      @(negedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cur_frames = (frm == 0) ? 1 : ((frm > 16) ? 16 : frm);
    cur_psize  = (psz == 0) ? 1 : psz;
    cur_pages  = '{pg0, pg1, pg2, pg3};
    foreach (cur_pages[k]) begin
      if (cur_pages[k] == 0) cur_pages[k] = 1;
      if (cur_pages[k] > 64) cur_pages[k] = 64;
    end
    @(negedge clk_i);
  endtask

  // Mostly a small working set per process so hits and evictions both occur
  task automatic random_beat();
    int p, pg, span, sel;
    p   = $urandom_range(0, 3);
    sel = $urandom_range(0, 99);
    if (sel == 0) begin
      send_beat(1'b1, $urandom_range(0, 3), $urandom_range(0, 32767));
    end else if (sel < 6) begin
      send_beat(1'b0, p, $urandom_range(0, 32767));
    end else begin
      span = cur_frames + 3;
      if (span > cur_pages[p] - 1) span = cur_pages[p] - 1;
      if (sel < 12) pg = $urandom_range(0, cur_pages[p]);  // may step one past the end
      else pg = $urandom_range(0, span);
      send_beat(1'b0, p, pg * cur_psize + $urandom_range(0, cur_psize - 1));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: accesses before any init fill free frames, then init and extremes
    send_beat(1'b0, 0, 0);
    send_beat(1'b0, 0, 32 * 63 + 31);
    send_beat(1'b0, 3, 32767);                        // beyond the page count
    send_beat(1'b1, 2, 12345);                        // init ignores its fields
    for (int i = 0; i < 4; i++) send_beat(1'b0, 1, i * 32 + 7);   // hits
    for (int i = 4; i < 9; i++) send_beat(1'b0, 1, i * 32);       // FIFO evictions
    send_beat(1'b0, 3, 2047);
    drain();
    // Clock with prepaging on two frames: the second load must spare the new page
    write_regs(POL_CLOCK, 1, 2, 512, 64, 64, 64, 2);
    send_beat(1'b1, 0, 0);
    send_beat(1'b0, 0, 0);
    send_beat(1'b0, 0, 5 * 512);
    send_beat(1'b0, 0, 5 * 512 + 511);
    send_beat(1'b0, 0, 63 * 512);                     // last page: nothing above it
    send_beat(1'b0, 3, 1 * 512);
    send_beat(1'b0, 3, 2 * 512);                      // one page past a two-page process
    send_beat(1'b0, 2, 32767);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) idling_on = 1'b0;
      write_regs(ph_pol[ph], ph_pre[ph], ph_frm[ph], ph_psz[ph],
                 ph_pgs[ph][0], ph_pgs[ph][1], ph_pgs[ph][2], ph_pgs[ph][3]);
      if (ph_init[ph]) send_beat(1'b1, 0, 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && ph == 1) drain();
        random_beat();
      end
      drain();
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/prp_pkg.sv
src/prp_ram.sv
src/page_replacement_policy.sv
tb/prp_checker.sv
tb/testbench.sv
